>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    localparam int QUEUE_DEPTH  = 8;
    localparam int RANK_BITS    = 16;
    localparam int VALUE_W      = 32;
    localparam int RANK_FIELD_W = 16;
    localparam int COUNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [RANK_BITS-1:0]      rank;
    } t_entry;

    typedef struct packed {
        logic   insert;
        logic   remove;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

>>> rtl/sorted_priority_queue_core.sv
`timescale 1ns / 1ps

// Bounded priority queue of value/rank pairs, highest rank first.
// Input channel (i_valid / o_ready): one transfer carries an operation,
// enqueue or dequeue, with a value and a rank for enqueue.
// Output channel (o_valid / i_ready): exactly one result per input transfer,
// giving the dequeued value, the top pair and count after the operation,
// and a status (ok, full and enqueue dropped, empty dequeue).
// Among equal ranks the most recently enqueued pair leaves first.
// Pairs live in a row of cells ordered top first; every cell decides its
// next content from its neighbors in the same cycle, so a new item is
// taken every cycle unless a pending result stalls the output.
// Latency: the result is valid the cycle after the input transfer.
// The result sits in an output register; while the receiver stalls with
// a result pending, o_ready drops and the queue holds. When the pending
// result is taken in a cycle, a new item is accepted in that same cycle.
// Reset empties the queue and clears the pending result.
module sorted_priority_queue_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_operation,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_item_value,
    input  logic [spq_pkg::RANK_FIELD_W-1:0]    i_item_rank,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [spq_pkg::VALUE_W-1:0]  o_removed_value,
    output logic signed [spq_pkg::VALUE_W-1:0]  o_top_value,
    output logic [spq_pkg::RANK_FIELD_W-1:0]    o_top_rank,
    output logic [spq_pkg::COUNT_W-1:0]         o_entry_count,
    output logic [1:0]                          o_status
);
    import spq_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_out_valid;

    logic signed [VALUE_W-1:0] r_removed;
    logic signed [VALUE_W-1:0] r_top_value;
    logic [RANK_FIELD_W-1:0]   r_top_rank;
    logic [COUNT_W-1:0]        r_out_count;
    t_status                   r_status;

    logic      accept;
    logic      full;
    logic      empty;
    logic      do_insert;
    logic      do_remove;
    t_status   status;
    t_cell_ctl ctl;

    t_entry cell_entry [QUEUE_DEPTH];
    t_entry cell_next  [QUEUE_DEPTH];
    logic   cell_keep  [QUEUE_DEPTH];

    assign o_ready   = !r_out_valid || i_ready;
    assign accept    = i_valid && o_ready;
    assign full      = (r_count == COUNT_W'(QUEUE_DEPTH));
    assign empty     = (r_count == '0);
    assign do_insert = accept && (i_operation == OP_ENQUEUE) && !full;
    assign do_remove = accept && (i_operation == OP_DEQUEUE) && !empty;

    assign ctl.insert          = do_insert;
    assign ctl.remove          = do_remove;
    assign ctl.new_entry.value = i_item_value;
    assign ctl.new_entry.rank  = i_item_rank[RANK_BITS-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            t_entry prev_entry;
            t_entry next_entry;
            logic   prev_keep;

            if (gi == 0) begin : g_head
                assign prev_entry = '0;
                assign prev_keep  = 1'b1;
            end else begin : g_body
                assign prev_entry = cell_entry[gi-1];
                assign prev_keep  = cell_keep[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign next_entry = '0;
            end else begin : g_link
                assign next_entry = cell_entry[gi+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_occupied   (r_count > COUNT_W'(gi)),
                .i_prev_keep  (prev_keep),
                .i_prev_entry (prev_entry),
                .i_next_entry (next_entry),
                .o_entry      (cell_entry[gi]),
                .o_next_state (cell_next[gi]),
                .o_keep       (cell_keep[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        status  = ST_OK;
        priority if (accept && (i_operation == OP_ENQUEUE) && full) begin
            status = ST_FULL;
        end else if (accept && (i_operation == OP_DEQUEUE) && empty) begin
            status = ST_EMPTY;
        end else if (do_insert) begin
            n_count = r_count + COUNT_W'(1);
        end else if (do_remove) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // capture the result alongside the cell update
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_removed   <= do_remove ? cell_entry[0].value : '0;
            r_out_count <= n_count;
            r_status    <= status;
            if (n_count == '0) begin
                r_top_value <= '0;
                r_top_rank  <= '0;
            end else begin
                r_top_value <= cell_next[0].value;
                r_top_rank  <= RANK_FIELD_W'(cell_next[0].rank);
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_removed_value = r_removed;
    assign o_top_value     = r_top_value;
    assign o_top_rank      = r_top_rank;
    assign o_entry_count   = r_out_count;
    assign o_status        = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |->
        (r_out_count == COUNT_W'(QUEUE_DEPTH) && r_removed == '0))
        else $error("full status without a full queue");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_EMPTY) |->
        (r_out_count == '0 && r_removed == '0))
        else $error("empty status without an empty queue");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_count == '0) |->
        (r_top_value == '0 && r_top_rank == '0))
        else $error("top pair reported on an empty queue");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_count == $past(n_count) && r_out_count == r_count))
        else $error("result count differs from queue count");

endmodule

>>> rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  logic               i_prev_keep,
    input  spq_pkg::t_entry    i_prev_entry,
    input  spq_pkg::t_entry    i_next_entry,
    output spq_pkg::t_entry    o_entry,
    output spq_pkg::t_entry    o_next_state,
    output logic               o_keep
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // hold the slot when it outranks the incoming pair; equal ranks yield
    assign o_keep = i_occupied && (r_entry.rank > i_ctl.new_entry.rank);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert && !o_keep) begin
            n_entry = i_prev_keep ? i_ctl.new_entry : i_prev_entry;
        end else if (i_ctl.remove) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry      = r_entry;
    assign o_next_state = n_entry;

endmodule
